/* rtl/core/ssf_pkg.sv */
// ----------------------------------------------------------------------------
// ssf_pkg
// Shared types and codes for the separation steering force block.
// ----------------------------------------------------------------------------
package ssf_pkg;

  localparam int CfgW = 31;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_NEIGH = 2'd1;
  localparam logic [1:0] OP_FIN   = 2'd2;

  localparam logic [1:0] REG_MAX_SPEED = 2'd0;
  localparam logic [1:0] REG_MAX_FORCE = 2'd1;
  localparam logic [1:0] REG_SPACING   = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
  } ssf_in_t;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic [15:0]        neighbors_used;
  } ssf_out_t;

endpackage

/* rtl/core/ssf_if.sv */
// ----------------------------------------------------------------------------
// ssf_if
// Valid/ready channels carrying the block's input and result transactions.
// ----------------------------------------------------------------------------
interface ssf_in_if;
  import ssf_pkg::*;
  logic    valid;
  logic    ready;
  ssf_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ssf_out_if;
  import ssf_pkg::*;
  logic     valid;
  logic     ready;
  ssf_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/separation_steering_force.sv */
// One transaction at a time: input is ready only while idle. A load, or a neighbor
// rejected on a component, is taken without leaving idle; a neighbor rejected on
// distance returns after the square root, an accepted one after the divides. The
// bit-serial multiplier, square root and divider work one bit per cycle.
// Reset (rst, synchronous): registers to defaults, own state and sums cleared.
// ----------------------------------------------------------------------------
// separation_steering_force
// Boids separation steering force with bit-serial mul, sqrt and divide units.
// ----------------------------------------------------------------------------
module separation_steering_force #(
  parameter int FRACTION_BITS = 16,
  parameter int COUNT_MAX     = 65535
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [ssf_pkg::CfgW-1:0]   cfg_wdata,
  ssf_in_if.sink                     din,
  ssf_out_if.source                  dout
);
  import ssf_pkg::*;

  localparam logic [15:0] CNT_SAT = COUNT_MAX[15:0];

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SQ    = 4'd1;
  localparam logic [3:0] S_SQRT  = 4'd2;
  localparam logic [3:0] S_NDIV  = 4'd3;
  localparam logic [3:0] S_AVG   = 4'd4;
  localparam logic [3:0] S_NORM  = 4'd5;
  localparam logic [3:0] S_PMUL  = 4'd6;
  localparam logic [3:0] S_PDIV  = 4'd7;
  localparam logic [3:0] S_STEER = 4'd8;
  localparam logic [3:0] S_LMF   = 4'd9;
  localparam logic [3:0] S_LSQ   = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  localparam logic [1:0] M_NB  = 2'd0;
  localparam logic [1:0] M_SPD = 2'd1;
  localparam logic [1:0] M_LIM = 2'd2;

  logic [30:0]        max_speed, max_force, spacing;
  logic signed [31:0] own_x, own_y, own_vx, own_vy;
  logic signed [47:0] sum_x, sum_y;
  logic [15:0]        count;
  logic [3:0]         state;
  logic [1:0]         mode, sub;
  logic [5:0]         cnt;
  logic [48:0]        ux, uy;
  logic               sx_neg, sy_neg;
  logic [63:0]        mc, acc;
  logic [30:0]        mp;
  logic [33:0]        srem;
  logic [31:0]        root;
  logic [63:0]        dq;
  logic [31:0]        dr, dvs;
  logic [31:0]        res_x;
  logic [61:0]        sq_lim;

  // serial step datapaths
  logic [63:0] mul_next;
  logic [35:0] sq_t, sq_trial, sq_diff;
  logic        sq_ge;
  logic [31:0] root_next;
  logic [32:0] div_t, div_diff;
  logic        div_ge;
  logic [31:0] dr_next;
  logic [63:0] q_next;

  assign mul_next  = mp[0] ? acc + mc : acc;
  assign sq_t      = {srem, acc[63:62]};
  assign sq_trial  = {2'b00, root, 2'b01};
  assign sq_ge     = sq_t >= sq_trial;
  assign sq_diff   = sq_t - sq_trial;
  assign root_next = {root[30:0], sq_ge};
  assign div_t     = {dr, dq[63]};
  assign div_ge    = div_t >= {1'b0, dvs};
  assign div_diff  = div_t - {1'b0, dvs};
  assign dr_next   = div_ge ? div_diff[31:0] : div_t[31:0];
  assign q_next    = {dq[62:0], div_ge};

  // neighbor offsets
  logic [32:0] nb_dx, nb_dy, nb_ax, nb_ay, th33;
  logic        nb_near;
  assign nb_dx   = {own_x[31], own_x} - {din.data.pos_x[31], din.data.pos_x};
  assign nb_dy   = {own_y[31], own_y} - {din.data.pos_y[31], din.data.pos_y};
  assign nb_ax   = nb_dx[32] ? 33'd0 - nb_dx : nb_dx;
  assign nb_ay   = nb_dy[32] ? 33'd0 - nb_dy : nb_dy;
  assign th33    = {2'b00, spacing};
  assign nb_near = (nb_ax < th33) && (nb_ay < th33);

  logic [47:0] mag_sx, mag_sy;
  assign mag_sx = sum_x[47] ? 48'd0 - sum_x : sum_x;
  assign mag_sy = sum_y[47] ? 48'd0 - sum_y : sum_y;

  logic [48:0] nrm_or;
  assign nrm_or = ux | uy;

  logic [30:0] len_sel;
  assign len_sel = (mode == M_LIM) ? max_force : max_speed;

  // steer = desired - velocity
  logic [33:0] st_vx, st_vy, st_sx, st_sy, st_mx, st_my, mf34;
  assign st_vx = sx_neg ? 34'd0 - ux[33:0] : ux[33:0];
  assign st_vy = sy_neg ? 34'd0 - uy[33:0] : uy[33:0];
  assign st_sx = st_vx - {{2{own_vx[31]}}, own_vx};
  assign st_sy = st_vy - {{2{own_vy[31]}}, own_vy};
  assign st_mx = st_sx[33] ? 34'd0 - st_sx : st_sx;
  assign st_my = st_sy[33] ? 34'd0 - st_sy : st_sy;
  assign mf34  = {3'b000, max_force};

  function automatic logic signed [47:0] sat_add(logic signed [47:0] s, logic neg,
                                                 logic [48:0] m);
    logic [49:0] mv;
    logic [49:0] r;
    mv = neg ? 50'd0 - {1'b0, m} : {1'b0, m};
    r  = {{2{s[47]}}, s} + mv;
    if (r[49:47] == 3'b000 || r[49:47] == 3'b111) begin
      return r[47:0];
    end else if (r[49]) begin
      return {1'b1, 47'd0};
    end else begin
      return {1'b0, {47{1'b1}}};
    end
  endfunction

  assign din.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed  <= 31'd131072;
      max_force  <= 31'd65536;
      spacing    <= 31'd1310720;
      own_x      <= '0;
      own_y      <= '0;
      own_vx     <= '0;
      own_vy     <= '0;
      sum_x      <= '0;
      sum_y      <= '0;
      count      <= '0;
      state      <= S_IDLE;
      mode       <= M_NB;
      sub        <= '0;
      cnt        <= '0;
      dout.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_SPEED: max_speed <= cfg_wdata;
          REG_MAX_FORCE: max_force <= cfg_wdata;
          REG_SPACING:   spacing   <= cfg_wdata;
          default: ;
        endcase
      end
      if (dout.valid && dout.ready && state != S_OUT) begin
        dout.valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (din.valid) begin
            case (din.data.op)
              OP_LOAD: begin
                own_x  <= din.data.pos_x;
                own_y  <= din.data.pos_y;
                own_vx <= din.data.vel_x;
                own_vy <= din.data.vel_y;
                sum_x  <= '0;
                sum_y  <= '0;
                count  <= '0;
              end
              OP_NEIGH: begin
                if (nb_near) begin
                  ux     <= {16'd0, nb_ax};
                  uy     <= {16'd0, nb_ay};
                  sx_neg <= nb_dx[32];
                  sy_neg <= nb_dy[32];
                  mc     <= {33'd0, nb_ax[30:0]};
                  mp     <= nb_ax[30:0];
                  acc    <= '0;
                  cnt    <= 6'd30;
                  sub    <= 2'd0;
                  mode   <= M_NB;
                  state  <= S_SQ;
                end
              end
              OP_FIN: begin
                if (count == 16'd0) begin
                  ux     <= '0;
                  uy     <= '0;
                  sx_neg <= 1'b0;
                  sy_neg <= 1'b0;
                  state  <= S_OUT;
                end else begin
                  sx_neg <= sum_x[47];
                  sy_neg <= sum_y[47];
                  dq     <= {16'd0, mag_sx};
                  dr     <= '0;
                  dvs    <= {16'd0, count};
                  cnt    <= 6'd63;
                  sub    <= 2'd0;
                  state  <= S_AVG;
                end
              end
              default: ;
            endcase
          end
        end

        S_SQ: begin
          acc <= mul_next;
          mc  <= {mc[62:0], 1'b0};
          mp  <= {1'b0, mp[30:1]};
          cnt <= cnt - 6'd1;
          if (cnt == 6'd0) begin
            if (sub == 2'd0) begin
              mc  <= {33'd0, uy[30:0]};
              mp  <= uy[30:0];
              cnt <= 6'd30;
              sub <= 2'd1;
            end else begin
              srem  <= '0;
              root  <= '0;
              cnt   <= 6'd31;
              state <= S_SQRT;
            end
          end
        end

        S_SQRT: begin
          srem <= sq_ge ? sq_diff[33:0] : sq_t[33:0];
          root <= root_next;
          acc  <= {acc[61:0], 2'b00};
          cnt  <= cnt - 6'd1;
          if (cnt == 6'd0) begin
            if (mode == M_NB) begin
              if (root_next == 32'd0 || root_next >= {1'b0, spacing}) begin
                state <= S_IDLE;
              end else begin
                dvs   <= root_next;
                dq    <= 64'(ux[30:0]) << FRACTION_BITS;
                dr    <= '0;
                cnt   <= 6'd63;
                sub   <= 2'd0;
                state <= S_NDIV;
              end
            end else begin
              dvs   <= root_next;
              mc    <= {33'd0, ux[30:0]};
              mp    <= len_sel;
              acc   <= '0;
              cnt   <= 6'd30;
              sub   <= 2'd0;
              state <= S_PMUL;
            end
          end
        end

        S_NDIV: begin
          dq  <= q_next;
          dr  <= dr_next;
          cnt <= cnt - 6'd1;
          if (cnt == 6'd0) begin
            dr  <= '0;
            cnt <= 6'd63;
            sub <= sub + 2'd1;
            case (sub)
              2'd0: dq <= q_next << FRACTION_BITS;
              2'd1: begin
                sum_x <= sat_add(sum_x, sx_neg, q_next[48:0]);
                dq    <= 64'(uy[30:0]) << FRACTION_BITS;
              end
              2'd2: dq <= q_next << FRACTION_BITS;
              default: begin
                sum_y <= sat_add(sum_y, sy_neg, q_next[48:0]);
                if (count != CNT_SAT) begin
                  count <= count + 16'd1;
                end
                state <= S_IDLE;
              end
            endcase
          end
        end

        S_AVG: begin
          dq  <= q_next;
          dr  <= dr_next;
          cnt <= cnt - 6'd1;
          if (cnt == 6'd0) begin
            if (sub == 2'd0) begin
              ux  <= q_next[48:0];
              dq  <= {16'd0, mag_sy};
              dr  <= '0;
              cnt <= 6'd63;
              sub <= 2'd1;
            end else begin
              uy    <= q_next[48:0];
              mode  <= M_SPD;
              state <= S_NORM;
            end
          end
        end

        S_NORM: begin
          if (nrm_or == 49'd0) begin
            state <= (mode == M_SPD) ? S_STEER : S_OUT;
          end else if (|nrm_or[48:31]) begin
            ux <= {1'b0, ux[48:1]};
            uy <= {1'b0, uy[48:1]};
          end else if (!nrm_or[30]) begin
            ux <= {ux[47:0], 1'b0};
            uy <= {uy[47:0], 1'b0};
          end else begin
            mc    <= {33'd0, ux[30:0]};
            mp    <= ux[30:0];
            acc   <= '0;
            cnt   <= 6'd30;
            sub   <= 2'd0;
            state <= S_SQ;
          end
        end

        S_PMUL: begin
          acc <= mul_next;
          mc  <= {mc[62:0], 1'b0};
          mp  <= {1'b0, mp[30:1]};
          cnt <= cnt - 6'd1;
          if (cnt == 6'd0) begin
            dq    <= mul_next;
            dr    <= '0;
            cnt   <= 6'd63;
            state <= S_PDIV;
          end
        end

        S_PDIV: begin
          dq  <= q_next;
          dr  <= dr_next;
          cnt <= cnt - 6'd1;
          if (cnt == 6'd0) begin
            if (sub == 2'd0) begin
              res_x <= q_next[31:0];
              mc    <= {33'd0, uy[30:0]};
              mp    <= len_sel;
              acc   <= '0;
              cnt   <= 6'd30;
              sub   <= 2'd1;
              state <= S_PMUL;
            end else begin
              ux    <= {17'd0, res_x};
              uy    <= {17'd0, q_next[31:0]};
              state <= (mode == M_SPD) ? S_STEER : S_OUT;
            end
          end
        end

        S_STEER: begin
          ux     <= {15'd0, st_mx};
          uy     <= {15'd0, st_my};
          sx_neg <= st_sx[33];
          sy_neg <= st_sy[33];
          if (st_mx > mf34 || st_my > mf34) begin
            mode  <= M_LIM;
            state <= S_NORM;
          end else begin
            mc    <= {33'd0, max_force};
            mp    <= max_force;
            acc   <= '0;
            cnt   <= 6'd30;
            state <= S_LMF;
          end
        end

        S_LMF: begin
          acc <= mul_next;
          mc  <= {mc[62:0], 1'b0};
          mp  <= {1'b0, mp[30:1]};
          cnt <= cnt - 6'd1;
          if (cnt == 6'd0) begin
            sq_lim <= mul_next[61:0];
            mc     <= {33'd0, ux[30:0]};
            mp     <= ux[30:0];
            acc    <= '0;
            cnt    <= 6'd30;
            sub    <= 2'd0;
            state  <= S_LSQ;
          end
        end

        S_LSQ: begin
          acc <= mul_next;
          mc  <= {mc[62:0], 1'b0};
          mp  <= {1'b0, mp[30:1]};
          cnt <= cnt - 6'd1;
          if (cnt == 6'd0) begin
            if (sub == 2'd0) begin
              mc  <= {33'd0, uy[30:0]};
              mp  <= uy[30:0];
              cnt <= 6'd30;
              sub <= 2'd1;
            end else if (mul_next > {2'b00, sq_lim}) begin
              mode  <= M_LIM;
              state <= S_NORM;
            end else begin
              state <= S_OUT;
            end
          end
        end

        S_OUT: begin
          if (!dout.valid || dout.ready) begin
            dout.valid               <= 1'b1;
            dout.data.force_x        <= sx_neg ? 32'd0 - ux[31:0] : ux[31:0];
            dout.data.force_y        <= sy_neg ? 32'd0 - uy[31:0] : uy[31:0];
            dout.data.neighbors_used <= count;
            state                    <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/ssf_check.sv */
// ----------------------------------------------------------------------------
// ssf_check
// Port-level assertions for the separation steering force block.
// ----------------------------------------------------------------------------
module ssf_check (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_op,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_fx,
  input logic [31:0] out_fy,
  input logic [15:0] out_used
);
  import ssf_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_fin_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_op == OP_FIN |=> !in_ready)
    else $error("accepted a transaction right after finish");

  a_zero_force: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_used == 16'd0 |-> out_fx == 32'd0 && out_fy == 32'd0)
    else $error("nonzero force with no neighbors");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_op != OP_FIN && !out_valid |=> !out_valid)
    else $error("result without a finish transaction");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind separation_steering_force ssf_check u_ssf_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (din.valid),
  .in_ready  (din.ready),
  .in_op     (din.data.op),
  .out_valid (dout.valid),
  .out_ready (dout.ready),
  .out_fx    (dout.data.force_x),
  .out_fy    (dout.data.force_y),
  .out_used  (dout.data.neighbors_used)
);

/* bench/separation_steering_force_tb.sv */
// ----------------------------------------------------------------------------
// separation_steering_force_tb
// Self-checking bench: directed and random load/neighbor/finish and invalid-op transactions,
// a fixed-point predictor of the separation force, randomized idling and a
// long receiver hold-off, with configuration changes between phases.
// ----------------------------------------------------------------------------
module separation_steering_force_tb;
  import ssf_pkg::*;

  localparam int FB = 16;
  localparam int CNT_MAX = 65535;
  localparam longint SUM_HI = 64'sh7FFF_FFFF_FFFF;
  localparam longint SUM_LO = -SUM_HI - 1;
  localparam logic [1:0] OP_BAD = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_MAX_SPEED;
  logic [CfgW-1:0] cfg_wdata = '0;

  ssf_in_if din ();
  ssf_out_if dout ();

  separation_steering_force dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .din(din.sink), .dout(dout.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  longint unsigned speed_lim, force_lim, spacing;
  longint own_px, own_py, own_vx, own_vy, acc_x, acc_y;
  int unsigned close_cnt;

  ssf_in_t pending_q[$];
  ssf_out_t force_q[$];
  int errors = 0;
  int send_idle = 16, recv_idle = 75;
  int hold_cycles = 0;

  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned absval(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic void rescale(input longint vx, input longint vy,
                                  input longint unsigned len,
                                  output longint ox, output longint oy);
    longint unsigned ux = absval(vx), uy = absval(vy), m, mg, rx, ry;
    m = ux > uy ? ux : uy;
    if (m == 0) begin
      ox = 0;
      oy = 0;
      return;
    end
    while (m >= (64'd1 << 31)) begin ux >>= 1; uy >>= 1; m >>= 1; end
    while (m < (64'd1 << 30)) begin ux <<= 1; uy <<= 1; m <<= 1; end
    mg = root64(ux * ux + uy * uy);
    rx = ux * len / mg;
    ry = uy * len / mg;
    ox = vx < 0 ? -longint'(rx) : longint'(rx);
    oy = vy < 0 ? -longint'(ry) : longint'(ry);
  endfunction

  function automatic longint clamp48(longint v);
    if (v > SUM_HI) return SUM_HI;
    if (v < SUM_LO) return SUM_LO;
    return v;
  endfunction

  function automatic void predict_force(ssf_in_t it);
    longint dx, dy, sx, sy, dvx, dvy;
    longint unsigned ax, ay, d, tx, ty, ux, uy;
    ssf_out_t r;
    case (it.op)
      OP_LOAD: begin
        own_px = longint'(it.pos_x); own_py = longint'(it.pos_y);
        own_vx = longint'(it.vel_x); own_vy = longint'(it.vel_y);
        acc_x = 0; acc_y = 0; close_cnt = 0;
      end
      OP_NEIGH: begin
        dx = own_px - longint'(it.pos_x);
        dy = own_py - longint'(it.pos_y);
        ax = absval(dx); ay = absval(dy);
        if (ax < spacing && ay < spacing) begin
          d = root64(ax * ax + ay * ay);
          if (d != 0 && d < spacing) begin
            tx = ((ax << FB) / d << FB) / d;
            ty = ((ay << FB) / d << FB) / d;
            acc_x = clamp48(acc_x + (dx < 0 ? -longint'(tx) : longint'(tx)));
            acc_y = clamp48(acc_y + (dy < 0 ? -longint'(ty) : longint'(ty)));
            if (close_cnt < CNT_MAX) close_cnt++;
          end
        end
      end
      OP_FIN: begin
        if (close_cnt == 0) begin
          r = '0;
        end else begin
          rescale(acc_x / longint'(close_cnt), acc_y / longint'(close_cnt),
                  speed_lim, dvx, dvy);
          sx = dvx - own_vx;
          sy = dvy - own_vy;
          ux = absval(sx); uy = absval(sy);
          if (ux > force_lim || uy > force_lim ||
              ux * ux + uy * uy > force_lim * force_lim)
            rescale(sx, sy, force_lim, sx, sy);
          r.force_x = sx[31:0];
          r.force_y = sy[31:0];
          r.neighbors_used = close_cnt[15:0];
        end
        force_q.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      din.valid <= 1'b0;
    end else if (!din.valid || din.ready) begin
      if (din.valid) predict_force(din.data);
      if (pending_q.size() > 0 && $urandom_range(99) >= send_idle) begin
        din.data <= pending_q.pop_front();
        din.valid <= 1'b1;
      end else begin
        din.valid <= 1'b0;
      end
    end
  end

  // monitor and receiver
  always @(posedge clk) begin
    ssf_out_t e;
    if (rst) begin
      dout.ready <= 1'b0;
    end else begin
      if (dout.valid && dout.ready) begin
        if (force_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %h", dout.data);
        end else begin
          e = force_q.pop_front();
          if (dout.data.force_x !== e.force_x || dout.data.force_y !== e.force_y ||
              dout.data.neighbors_used !== e.neighbors_used) begin
            errors++;
            if (errors <= 10)
              $display("mismatch exp x=%h y=%h n=%0d got x=%h y=%h n=%0d",
                       e.force_x, e.force_y, e.neighbors_used, dout.data.force_x,
                       dout.data.force_y, dout.data.neighbors_used);
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        dout.ready <= 1'b0;
      end else begin
        dout.ready <= $urandom_range(99) >= recv_idle;
      end
    end
  end

  initial begin
    din.valid = 1'b0;
    din.data = '0;
    dout.ready = 1'b0;
  end

  task automatic write_reg(input logic [1:0] idx, input longint unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CfgW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MAX_SPEED: speed_lim = val & 64'h7FFF_FFFF;
      REG_MAX_FORCE: force_lim = val & 64'h7FFF_FFFF;
      default: spacing = val & 64'h7FFF_FFFF;
    endcase
  endtask

  task automatic push(input logic [1:0] op, input int px, input int py,
                      input int vx, input int vy);
    ssf_in_t it;
    it.op = op; it.pos_x = px; it.pos_y = py; it.vel_x = vx; it.vel_y = vy;
    pending_q.push_back(it);
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || din.valid || force_q.size() > 0) @(posedge clk);
    repeat (1000) @(posedge clk);
  endtask

  function automatic int near_val(int base, int span);
    return base + $signed($urandom_range(2 * span)) - span;
  endfunction

  task automatic random_phase(input int n);
    int ox, oy, k, span;
    for (int i = 0; i < n;) begin
      if ($urandom_range(9) == 0) begin
        push(2'($urandom_range(3)), $urandom, $urandom, $urandom, $urandom);
        i++;
      end else begin
        ox = $urandom; oy = $urandom;
        span = (spacing > 64'd1 << 30) ? 32'h3FFF_FFFF : int'(spacing);
        span = span < 4 ? 4 : span;
        push(OP_LOAD, ox, oy, $urandom, $urandom);
        k = $urandom_range(5);
        for (int j = 0; j < k; j++)
          push(OP_NEIGH, near_val(ox, span), near_val(oy, span), $urandom, $urandom);
        push(OP_FIN, $urandom, $urandom, $urandom, $urandom);
        i += k + 2;
        if ($urandom_range(4) == 0) begin
          push(OP_FIN, 0, 0, 0, 0);
          i++;
        end
      end
    end
  endtask

  initial begin
    speed_lim = 131072; force_lim = 65536; spacing = 1310720;
    own_px = 0; own_py = 0; own_vx = 0; own_vy = 0;
    acc_x = 0; acc_y = 0; close_cnt = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // directed
    push(OP_FIN, 0, 0, 0, 0);
    push(OP_NEIGH, 32'h0001_0000, 0, 0, 0);
    push(OP_FIN, 0, 0, 0, 0);
    push(OP_LOAD, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
    push(OP_NEIGH, 0, 0, 0, 0);
    push(OP_NEIGH, 32'h0015_0000, 0, 0, 0);
    push(OP_NEIGH, 32'h000A_0000, 32'h000A_0000, 0, 0);
    push(OP_NEIGH, 32'hFFFF_0000, 32'h0002_0000, 0, 0);
    push(OP_NEIGH, 1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push(OP_BAD, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
    push(OP_FIN, 0, 0, 0, 0);
    push(OP_FIN, 0, 0, 0, 0);
    push(OP_LOAD, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
    push(OP_NEIGH, 32'h7FFF_FFF0, 32'h8000_0005, 0, 0);
    push(OP_NEIGH, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
    push(OP_FIN, 0, 0, 0, 0);
    // long hold-off while the sender keeps offering
    hold_cycles = 3000;
    drain();
    random_phase(180);
    drain();
    write_reg(REG_MAX_SPEED, 64'h7FFF_FFFF);
    write_reg(REG_MAX_FORCE, 64'd0);
    write_reg(REG_SPACING, 64'h7FFF_FFFF);
    send_idle = 75; recv_idle = 16;
    random_phase(90);
    drain();
    write_reg(REG_MAX_SPEED, 64'd0);
    write_reg(REG_MAX_FORCE, 64'h7FFF_FFFF);
    write_reg(REG_SPACING, 64'd0);
    push(OP_LOAD, 0, 0, 5, 5);
    push(OP_NEIGH, 1, 1, 0, 0);
    push(OP_FIN, 0, 0, 0, 0);
    random_phase(30);
    drain();
    write_reg(REG_MAX_SPEED, 64'h0003_0000);
    write_reg(REG_MAX_FORCE, 64'h0000_8000);
    write_reg(REG_SPACING, 64'h0000_0040);
    send_idle = 0; recv_idle = 0;
    random_phase(230);
    drain();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
